[rtl/core/reader_writer_lock_arbiter_assert.svh]
// Assertion macros shared by the checkers of the reader/writer lock arbiter.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef READER_WRITER_LOCK_ARBITER_ASSERT_SVH
`define READER_WRITER_LOCK_ARBITER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define RWLA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RWLA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rwla_pkg.sv]
// Package of the reader/writer lock arbiter: codes, field widths and the
// structs that join the controller and the datapath. Depends on nothing.
package rwla_pkg;

	localparam int AGENT_W     = 4;
	localparam int AGENT_NUM   = 1 << AGENT_W;
	localparam int STAMP_W     = 6;
	localparam int READER_W    = 5;
	localparam logic [READER_W-1:0] READER_MAX = 5'd31;
	localparam int MAX_RESULTS = 16;
	localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_BEGIN_READ  = 2'd0,
		OP_END_READ    = 2'd1,
		OP_BEGIN_WRITE = 2'd2,
		OP_END_WRITE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_GRANTED    = 2'd0,
		STAT_QUEUE_FULL = 2'd1,
		STAT_NO_HOLDER  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		POL_READER  = 2'd0,
		POL_WRITER  = 2'd1,
		POL_ARRIVAL = 2'd2
	} policy_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_DECIDE,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [AGENT_W-1:0] id;
		logic [STAMP_W-1:0] stamp;
	} qentry_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic grant;
		logic push_out;
		logic push_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic can_grant;
		logic pend_valid;
		logic out_free;
	} ctrl_sts_t;

endpackage

[rtl/core/reader_writer_lock_arbiter.sv]
// Reader/writer lock arbiter: grants shared read and exclusive write access
// under reader preference, writer preference or arrival order. A request holds
// the input stalled through the execute, head fetch, decision and flush states,
// and each grant adds a head fetch and a decision for the registered head read
// of the waiting-queue memories; a stalled result output holds the sequence.
// Results of one request end with last set; the output register lets the next
// result be prepared while one waits. Depends on rwla_pkg, rwla_ctrl and
// rwla_datapath.
module reader_writer_lock_arbiter #(
	parameter int QUEUE_DEPTH = 16,
	parameter int AGENT_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] op,
	input  logic [3:0] requester,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [3:0] granted_agent,
	output logic       grant_is_write,
	output logic [1:0] status,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] policy_mode
);

	rwla_pkg::ctrl_cmd_t cmd;
	rwla_pkg::ctrl_sts_t sts;
	logic                idle;

	assign req_stall = !(idle && arst_n);
	assign cfg_ready = idle && arst_n;

	rwla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle)
	);

	rwla_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.AGENT_COUNT (AGENT_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_policy    (policy_mode),
		.req_op        (op),
		.req_requester (requester),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.rsp_agent     (granted_agent),
		.rsp_write     (grant_is_write),
		.rsp_status    (status),
		.rsp_last      (last)
	);

endmodule

[rtl/core/rwla_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the waiting queues; depends on nothing.
module rwla_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/rwla_ctrl.sv]
// Controller of the reader/writer lock arbiter: sequences one request through
// execute, head fetch, grant decision and final flush. Depends on rwla_pkg.
module rwla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  rwla_pkg::ctrl_sts_t  sts,
	output rwla_pkg::ctrl_cmd_t  cmd,
	output logic                 idle
);

	rwla_pkg::state_t state_q;
	rwla_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwla_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwla_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = rwla_pkg::S_EXEC;
				end
			end
			rwla_pkg::S_EXEC: begin
				state_d = rwla_pkg::S_FETCH;
			end
			rwla_pkg::S_FETCH: begin
				state_d = rwla_pkg::S_DECIDE;
			end
			rwla_pkg::S_DECIDE: begin
				if (!sts.can_grant) begin
					state_d = rwla_pkg::S_FLUSH;
				end else if (!sts.pend_valid || sts.out_free) begin
					state_d = rwla_pkg::S_FETCH;
				end
			end
			rwla_pkg::S_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) begin
					state_d = rwla_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rwla_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		unique case (state_q)
			rwla_pkg::S_IDLE: begin
				idle        = 1'b1;
				cmd.capture = req_valid;
			end
			rwla_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			rwla_pkg::S_FETCH: begin
			end
			rwla_pkg::S_DECIDE: begin
				if (sts.can_grant && (!sts.pend_valid || sts.out_free)) begin
					cmd.grant    = 1'b1;
					cmd.push_out = sts.pend_valid;
				end
			end
			rwla_pkg::S_FLUSH: begin
				if (sts.pend_valid && sts.out_free) begin
					cmd.push_out  = 1'b1;
					cmd.push_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/rwla_datapath.sv]
// Datapath of the reader/writer lock arbiter: lock state, the two waiting
// queues with arrival stamps, grant selection and the result registers.
// Depends on rwla_pkg and rwla_ram.
module rwla_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int AGENT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rwla_pkg::ctrl_cmd_t           cmd,
	output rwla_pkg::ctrl_sts_t           sts,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_policy,
	input  logic [1:0]                    req_op,
	input  logic [rwla_pkg::AGENT_W-1:0]  req_requester,
	input  logic                          rsp_stall,
	output logic                          rsp_valid,
	output logic [rwla_pkg::AGENT_W-1:0]  rsp_agent,
	output logic                          rsp_write,
	output logic [1:0]                    rsp_status,
	output logic                          rsp_last
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = AW + 2;
	localparam int EW = $bits(rwla_pkg::qentry_t);

	logic [1:0]                         policy_q;
	rwla_pkg::op_t                      op_q;
	logic [rwla_pkg::AGENT_W-1:0]       id_q;
	logic [rwla_pkg::READER_W-1:0]      active_q;
	logic                               wbusy_q;
	logic [AW-1:0]                      rhead_q;
	logic [CW-1:0]                      rcnt_q;
	logic [AW-1:0]                      whead_q;
	logic [CW-1:0]                      wcnt_q;
	logic [rwla_pkg::STAMP_W-1:0]       stamp_q;
	logic [rwla_pkg::RESULT_CNT_W-1:0]  nres_q;
	logic                               pend_valid_q;
	logic [rwla_pkg::AGENT_W-1:0]       pend_agent_q;
	logic                               pend_write_q;
	rwla_pkg::status_t                  pend_status_q;
	logic                               rsp_valid_q;
	logic [rwla_pkg::AGENT_W-1:0]       rsp_agent_q;
	logic                               rsp_write_q;
	rwla_pkg::status_t                  rsp_status_q;
	logic                               rsp_last_q;

	logic [rwla_pkg::AGENT_W-1:0] mod_tbl [rwla_pkg::AGENT_NUM];
	logic [SW-1:0]                rsum;
	logic [SW-1:0]                wsum;
	logic [AW-1:0]                rtail;
	logic [AW-1:0]                wtail;
	logic                         rfull;
	logic                         wfull;
	logic                         r_push;
	logic                         w_push;
	logic [EW-1:0]                rram_rdata;
	logic [EW-1:0]                wram_rdata;
	rwla_pkg::qentry_t            rhead_entry;
	rwla_pkg::qentry_t            whead_entry;
	rwla_pkg::qentry_t            new_entry;
	logic [rwla_pkg::STAMP_W-1:0] age_r;
	logic [rwla_pkg::STAMP_W-1:0] age_w;
	logic                         rw;
	logic                         ww;
	logic                         want_r;
	logic                         want_w;
	logic                         grant_r;
	logic                         grant_w;
	logic                         exec_err;
	logic                         exec_err_write;
	rwla_pkg::status_t            exec_err_status;
	logic                         out_free;

	for (genvar g = 0; g < rwla_pkg::AGENT_NUM; g++) begin : g_mod
		localparam int MV = g % AGENT_COUNT;
		assign mod_tbl[g] = rwla_pkg::AGENT_W'(MV);
	end

	assign rfull = (rcnt_q == CW'(QUEUE_DEPTH));
	assign wfull = (wcnt_q == CW'(QUEUE_DEPTH));
	assign rsum  = SW'(rhead_q) + SW'(rcnt_q);
	assign wsum  = SW'(whead_q) + SW'(wcnt_q);
	assign rtail = (rsum >= SW'(QUEUE_DEPTH)) ? AW'(rsum - SW'(QUEUE_DEPTH)) : AW'(rsum);
	assign wtail = (wsum >= SW'(QUEUE_DEPTH)) ? AW'(wsum - SW'(QUEUE_DEPTH)) : AW'(wsum);

	assign r_push = cmd.exec && (op_q == rwla_pkg::OP_BEGIN_READ) && !rfull;
	assign w_push = cmd.exec && (op_q == rwla_pkg::OP_BEGIN_WRITE) && !wfull;
	assign new_entry.id    = id_q;
	assign new_entry.stamp = stamp_q;

	rwla_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_rqueue (
		.clk   (clk),
		.we    (r_push),
		.waddr (rtail),
		.wdata (new_entry),
		.raddr (rhead_q),
		.rdata (rram_rdata)
	);

	rwla_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_wqueue (
		.clk   (clk),
		.we    (w_push),
		.waddr (wtail),
		.wdata (new_entry),
		.raddr (whead_q),
		.rdata (wram_rdata)
	);

	assign rhead_entry = rram_rdata;
	assign whead_entry = wram_rdata;
	assign age_r = stamp_q - rhead_entry.stamp;
	assign age_w = stamp_q - whead_entry.stamp;
	assign rw = (rcnt_q != '0);
	assign ww = (wcnt_q != '0);

	always_comb begin
		want_r = 1'b0;
		want_w = 1'b0;
		case (policy_q)
			rwla_pkg::POL_READER: begin
				want_r = rw;
				want_w = !rw && ww;
			end
			rwla_pkg::POL_WRITER: begin
				want_w = ww;
				want_r = !ww && rw;
			end
			default: begin
				if (rw && ww) begin
					want_r = (age_r > age_w);
					want_w = !(age_r > age_w);
				end else begin
					want_r = rw;
					want_w = !rw && ww;
				end
			end
		endcase
	end

	assign grant_r = want_r && !wbusy_q && (active_q != rwla_pkg::READER_MAX);
	assign grant_w = want_w && !wbusy_q && (active_q == '0);

	always_comb begin
		exec_err        = 1'b0;
		exec_err_write  = 1'b0;
		exec_err_status = rwla_pkg::STAT_QUEUE_FULL;
		unique case (op_q)
			rwla_pkg::OP_BEGIN_READ: begin
				exec_err = rfull;
			end
			rwla_pkg::OP_END_READ: begin
				exec_err        = (active_q == '0);
				exec_err_status = rwla_pkg::STAT_NO_HOLDER;
			end
			rwla_pkg::OP_BEGIN_WRITE: begin
				exec_err       = wfull;
				exec_err_write = 1'b1;
			end
			rwla_pkg::OP_END_WRITE: begin
				exec_err        = !wbusy_q;
				exec_err_write  = 1'b1;
				exec_err_status = rwla_pkg::STAT_NO_HOLDER;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	assign sts.can_grant  = (grant_r || grant_w) &&
		(nres_q < rwla_pkg::RESULT_CNT_W'(rwla_pkg::MAX_RESULTS));
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= rwla_pkg::POL_READER;
			active_q     <= '0;
			wbusy_q      <= 1'b0;
			rhead_q      <= '0;
			rcnt_q       <= '0;
			whead_q      <= '0;
			wcnt_q       <= '0;
			stamp_q      <= '0;
			nres_q       <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_policy;
			end
			if (cmd.capture) begin
				nres_q <= '0;
			end
			if (cmd.exec) begin
				if (exec_err) begin
					pend_valid_q <= 1'b1;
					nres_q       <= nres_q + 1'b1;
				end else begin
					unique case (op_q)
						rwla_pkg::OP_BEGIN_READ: begin
							rcnt_q  <= rcnt_q + 1'b1;
							stamp_q <= stamp_q + 1'b1;
						end
						rwla_pkg::OP_END_READ: begin
							active_q <= active_q - 1'b1;
						end
						rwla_pkg::OP_BEGIN_WRITE: begin
							wcnt_q  <= wcnt_q + 1'b1;
							stamp_q <= stamp_q + 1'b1;
						end
						rwla_pkg::OP_END_WRITE: begin
							wbusy_q <= 1'b0;
						end
					endcase
				end
			end
			if (cmd.push_out && !cmd.grant) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.grant) begin
				pend_valid_q <= 1'b1;
				nres_q       <= nres_q + 1'b1;
				if (grant_r) begin
					active_q <= active_q + 1'b1;
					rcnt_q   <= rcnt_q - 1'b1;
					rhead_q  <= (rhead_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rhead_q + 1'b1;
				end else begin
					wbusy_q <= 1'b1;
					wcnt_q  <= wcnt_q - 1'b1;
					whead_q <= (whead_q == AW'(QUEUE_DEPTH - 1)) ? '0 : whead_q + 1'b1;
				end
			end
			if (cmd.push_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= rwla_pkg::op_t'(req_op);
			id_q <= mod_tbl[req_requester];
		end
		if (cmd.exec && exec_err) begin
			pend_agent_q  <= id_q;
			pend_write_q  <= exec_err_write;
			pend_status_q <= exec_err_status;
		end else if (cmd.grant) begin
			pend_agent_q  <= grant_r ? rhead_entry.id : whead_entry.id;
			pend_write_q  <= !grant_r;
			pend_status_q <= rwla_pkg::STAT_GRANTED;
		end
		if (cmd.push_out) begin
			rsp_agent_q  <= pend_agent_q;
			rsp_write_q  <= pend_write_q;
			rsp_status_q <= pend_status_q;
			rsp_last_q   <= cmd.push_last;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_agent  = rsp_agent_q;
	assign rsp_write  = rsp_write_q;
	assign rsp_status = rsp_status_q;
	assign rsp_last   = rsp_last_q;

endmodule

[rtl/core/rwla_checker.sv]
// Port-level checker of the reader/writer lock arbiter and its bind.
// Depends on rwla_pkg and reader_writer_lock_arbiter_assert.svh.
`include "reader_writer_lock_arbiter_assert.svh"

module rwla_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [3:0] granted_agent,
	input logic       grant_is_write,
	input logic [1:0] status,
	input logic       last,
	input logic       cfg_ready
);

	logic [7:0] rsp_word;

	assign rsp_word = {granted_agent, grant_is_write, status, last};

	`RWLA_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall && !cfg_ready, "not busy")
	`RWLA_ASSERT_NOW(a_cfg_idle, cfg_ready, !req_stall, "configuration ready while busy")
	`RWLA_ASSERT_NOW(a_status_code, rsp_valid, status <= rwla_pkg::STAT_NO_HOLDER, "bad status")
	`RWLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "moved")

endmodule

bind reader_writer_lock_arbiter rwla_checker u_rwla_checker (.*);
